@@ hdl/sfp_pkg.sv @@
// shared constants, types and helpers of the spectral fundamental picker
package sfp_pkg;

  localparam int MAX_BINS   = 8192;
  localparam int NUM_PEAKS  = 5;
  localparam int IDX_W      = $clog2(MAX_BINS);
  localparam int SLOT_W     = $clog2(NUM_PEAKS);
  localparam int FUND_W     = 13;
  localparam int FIRST_W    = 13;
  localparam int MARGIN_W   = 16;
  localparam int DATA_W     = 32;
  localparam int POW_W      = 64;
  localparam int PROD_W     = IDX_W + MARGIN_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int CMP_W      = (IDX_W > FIRST_W) ? IDX_W : FIRST_W;

  localparam int QDEPTH     = 8;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = QPTR_W + 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MARGIN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FIRST  = CFG_IDX_W'(1);

  localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(1966);
  localparam logic [FIRST_W-1:0]  FIRST_RESET  = FIRST_W'(10);
  localparam logic [IDX_W-1:0]    LAST_IDX     = IDX_W'(MAX_BINS - 1);
  localparam logic [PROD_W-1:0]   Q_ONE        = PROD_W'(65536);

  // harmonic divisors 2..6, reciprocals floor(65536 / d)
  localparam int MIN_DIV = 2;
  localparam int NUM_DIV = 5;
  localparam int RECIP_W = 17;
  localparam logic [RECIP_W-1:0] RECIP [NUM_DIV] = '{
    17'd32768, 17'd21845, 17'd16384, 17'd13107, 17'd10922
  };

  // one queue entry between front and back
  typedef struct packed {
    logic [POW_W-1:0]  power;
    logic [IDX_W-1:0]  idx;
    logic [PROD_W-1:0] slack;
    logic              take;
    logic              last;
  } sfp_entry_t;

  typedef struct packed {
    logic              valid;
    logic [QCNT_W-1:0] level;
  } sfp_qstat_t;

  // floor(n / (k + MIN_DIV)) by reciprocal multiply and one correction
  function automatic logic [IDX_W-1:0] div_by(input logic [IDX_W-1:0] n,
                                              input logic [2:0] k);
    logic [IDX_W+RECIP_W-1:0] prod;
    logic [IDX_W-1:0]         q;
    logic [IDX_W+3:0]         nxt;
    prod = (IDX_W+RECIP_W)'(n) * (IDX_W+RECIP_W)'(RECIP[k]);
    q    = prod[IDX_W+15:16];
    nxt  = ((IDX_W+4)'(q) + (IDX_W+4)'(1)) * ((IDX_W+4)'(k) + (IDX_W+4)'(MIN_DIV));
    if (nxt <= (IDX_W+4)'(n)) q = q + IDX_W'(1);
    return q;
  endfunction

endpackage

@@ hdl/sfp_front.sv @@
// front end: bin indexing, magnitude squares and spacing slack
module sfp_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          bin_valid,
  output logic                          bin_stall,
  input  logic signed [sfp_pkg::DATA_W-1:0] bin_real,
  input  logic signed [sfp_pkg::DATA_W-1:0] bin_imag,
  input  logic                          last_bin,
  input  logic [sfp_pkg::MARGIN_W-1:0]  margin_frac,
  input  logic [sfp_pkg::FIRST_W-1:0]   first_bin,
  input  sfp_pkg::sfp_qstat_t           qstat,
  output logic                          push_valid,
  output sfp_pkg::sfp_entry_t           push_data
);

  logic [sfp_pkg::IDX_W-1:0]  bin_count;

  logic                       a_valid;
  logic [sfp_pkg::DATA_W-1:0] a_re_mag, a_im_mag;
  logic [sfp_pkg::IDX_W-1:0]  a_idx;
  logic                       a_take, a_last;

  logic                       b_valid;
  logic [sfp_pkg::POW_W-1:0]  b_re_sq, b_im_sq;
  logic [sfp_pkg::PROD_W-1:0] b_prod;
  logic [sfp_pkg::IDX_W-1:0]  b_idx;
  logic                       b_take, b_last;

  logic [sfp_pkg::QCNT_W+1:0] occupancy;
  logic                       accept;
  logic [sfp_pkg::DATA_W-1:0] re_mag, im_mag;

  // queue slots already promised to items in flight
  assign occupancy = (sfp_pkg::QCNT_W+2)'(qstat.level) + (sfp_pkg::QCNT_W+2)'(a_valid)
                   + (sfp_pkg::QCNT_W+2)'(b_valid) + (sfp_pkg::QCNT_W+2)'(push_valid);
  assign bin_stall = rst || (occupancy >= (sfp_pkg::QCNT_W+2)'(sfp_pkg::QDEPTH));
  assign accept    = bin_valid && !bin_stall;

  assign re_mag = bin_real[sfp_pkg::DATA_W-1] ? (~bin_real + 1'b1) : bin_real;
  assign im_mag = bin_imag[sfp_pkg::DATA_W-1] ? (~bin_imag + 1'b1) : bin_imag;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_count  <= '0;
      a_valid    <= 1'b0;
      b_valid    <= 1'b0;
      push_valid <= 1'b0;
    end else begin
      a_valid    <= accept;
      b_valid    <= a_valid;
      push_valid <= b_valid;
      if (accept) begin
        if (last_bin) begin
          bin_count <= '0;
        end else if (bin_count != sfp_pkg::LAST_IDX) begin
          bin_count <= bin_count + 1'b1;
        end
      end
    end
    // payload
    a_re_mag <= re_mag;
    a_im_mag <= im_mag;
    a_idx    <= bin_count;
    a_take   <= sfp_pkg::CMP_W'(bin_count) >= sfp_pkg::CMP_W'(first_bin);
    a_last   <= last_bin;

    b_re_sq  <= sfp_pkg::POW_W'(a_re_mag) * sfp_pkg::POW_W'(a_re_mag);
    b_im_sq  <= sfp_pkg::POW_W'(a_im_mag) * sfp_pkg::POW_W'(a_im_mag);
    b_prod   <= sfp_pkg::PROD_W'(a_idx) * sfp_pkg::PROD_W'(margin_frac);
    b_idx    <= a_idx;
    b_take   <= a_take;
    b_last   <= a_last;

    push_data.power <= b_re_sq + b_im_sq;
    push_data.idx   <= b_idx;
    push_data.slack <= b_prod + sfp_pkg::Q_ONE;
    push_data.take  <= b_take;
    push_data.last  <= b_last;
  end

endmodule

@@ hdl/sfp_queue.sv @@
// small register fifo between front and back
module sfp_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  input  sfp_pkg::sfp_entry_t push_data,
  input  logic                pop,
  output sfp_pkg::sfp_entry_t head,
  output sfp_pkg::sfp_qstat_t qstat
);

  sfp_pkg::sfp_entry_t        entries [sfp_pkg::QDEPTH];
  logic [sfp_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [sfp_pkg::QCNT_W-1:0] count;

  assign head        = entries[rd_ptr];
  assign qstat.valid = (count != '0);
  assign qstat.level = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_valid) wr_ptr <= wr_ptr + 1'b1;
      if (pop)        rd_ptr <= rd_ptr + 1'b1;
      count <= count + sfp_pkg::QCNT_W'(push_valid) - sfp_pkg::QCNT_W'(pop);
    end
    if (push_valid) entries[wr_ptr] <= push_data;
  end

endmodule

@@ hdl/sfp_back.sv @@
// back end: top-five peak table, index sort, harmonic scan, result register
module sfp_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [sfp_pkg::MARGIN_W-1:0] margin_frac,
  input  sfp_pkg::sfp_qstat_t          qstat,
  input  sfp_pkg::sfp_entry_t          head,
  output logic                         pop,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [sfp_pkg::FUND_W-1:0]   fundamental_bin,
  output logic                         harmonic_found
);

  typedef enum logic [2:0] {ST_UPDATE, ST_SORT, ST_QUOT, ST_SCAN, ST_EMIT} state_t;

  state_t                      state;
  logic [sfp_pkg::POW_W-1:0]   peak_power [sfp_pkg::NUM_PEAKS];
  logic [sfp_pkg::IDX_W-1:0]   peak_index [sfp_pkg::NUM_PEAKS];
  logic [sfp_pkg::SLOT_W-1:0]  step;
  logic [sfp_pkg::IDX_W-1:0]   top, pick;
  logic [sfp_pkg::IDX_W-1:0]   quot [sfp_pkg::NUM_DIV];
  logic                        found;

  // insertion
  logic [sfp_pkg::SUM_W-1:0]   ii, hi;
  logic [sfp_pkg::SUM_W-1:0]   jj   [sfp_pkg::NUM_PEAKS];
  logic [sfp_pkg::NUM_PEAKS-1:0] gt, far;
  logic                        hit, blocked, ins_ok;
  logic [sfp_pkg::SLOT_W-1:0]  pos;

  // sort and scan
  logic [sfp_pkg::IDX_W-1:0]   sorted [sfp_pkg::NUM_PEAKS];
  logic [sfp_pkg::IDX_W-1:0]   scan_j;
  logic [sfp_pkg::SUM_W-1:0]   scan_jj, tol, qq;
  logic                        match;
  logic                        out_free;

  assign pop      = (state == ST_UPDATE) && qstat.valid;
  assign out_free = !result_valid || !result_stall;

  always_comb begin
    ii = sfp_pkg::SUM_W'({head.idx, {sfp_pkg::MARGIN_W{1'b0}}});
    hi = ii + sfp_pkg::SUM_W'(head.slack);
    for (int s = 0; s < sfp_pkg::NUM_PEAKS; s++) begin
      jj[s]  = sfp_pkg::SUM_W'({peak_index[s], {sfp_pkg::MARGIN_W{1'b0}}});
      far[s] = (jj[s] > hi) || ((jj[s] + sfp_pkg::SUM_W'(head.slack)) < ii);
      gt[s]  = head.power > peak_power[s];
    end
    hit = 1'b0;
    pos = '0;
    for (int p = 0; p < sfp_pkg::NUM_PEAKS; p++) begin
      if (!hit && gt[p]) begin
        hit = 1'b1;
        pos = sfp_pkg::SLOT_W'(p);
      end
    end
    blocked = 1'b0;
    for (int s = 0; s < sfp_pkg::NUM_PEAKS; s++) begin
      if ((sfp_pkg::SLOT_W'(s) < pos) && !far[s]) blocked = 1'b1;
    end
    ins_ok = head.take && hit && !blocked;
  end

  // one odd-even transposition pass, larger index moves toward slot 0
  always_comb begin
    for (int s = 0; s < sfp_pkg::NUM_PEAKS; s++) sorted[s] = peak_index[s];
    for (int k = 0; k < sfp_pkg::NUM_PEAKS - 1; k++) begin
      if ((k % 2) == int'(step[0]) && peak_index[k+1] > peak_index[k]) begin
        sorted[k]   = peak_index[k+1];
        sorted[k+1] = peak_index[k];
      end
    end
  end

  // bracket test of every quotient against one peak
  always_comb begin
    scan_j  = peak_index[step];
    scan_jj = sfp_pkg::SUM_W'({scan_j, {sfp_pkg::MARGIN_W{1'b0}}});
    tol     = sfp_pkg::SUM_W'(scan_j) * sfp_pkg::SUM_W'(margin_frac);
    match   = 1'b0;
    qq      = '0;
    for (int k = 0; k < sfp_pkg::NUM_DIV; k++) begin
      qq = sfp_pkg::SUM_W'({quot[k], {sfp_pkg::MARGIN_W{1'b0}}});
      if ((qq + tol > scan_jj) && (qq < scan_jj + tol)) match = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_UPDATE;
      result_valid <= 1'b0;
      step         <= '0;
      for (int s = 0; s < sfp_pkg::NUM_PEAKS; s++) begin
        peak_power[s] <= '0;
        peak_index[s] <= '0;
      end
    end else begin
      // in ST_EMIT the result register is reloaded instead of drained
      if (result_valid && !result_stall && state != ST_EMIT) result_valid <= 1'b0;
      unique case (state)
        ST_UPDATE: begin
          if (pop) begin
            if (ins_ok) begin
              for (int s = sfp_pkg::NUM_PEAKS - 1; s > 0; s--) begin
                if (sfp_pkg::SLOT_W'(s) > pos) begin
                  peak_power[s] <= peak_power[s-1];
                  peak_index[s] <= peak_index[s-1];
                end
              end
              peak_power[pos] <= head.power;
              peak_index[pos] <= head.idx;
            end
            if (head.last) begin
              state <= ST_SORT;
              step  <= '0;
            end
          end
        end
        ST_SORT: begin
          for (int s = 0; s < sfp_pkg::NUM_PEAKS; s++) peak_index[s] <= sorted[s];
          if (step == sfp_pkg::SLOT_W'(sfp_pkg::NUM_PEAKS - 1)) begin
            state <= ST_QUOT;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_QUOT: begin
          top   <= peak_index[0];
          pick  <= peak_index[0];
          found <= 1'b0;
          for (int k = 0; k < sfp_pkg::NUM_DIV; k++) begin
            quot[k] <= sfp_pkg::div_by(peak_index[0], 3'(k));
          end
          step  <= sfp_pkg::SLOT_W'(sfp_pkg::NUM_PEAKS - 1);
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (match) begin
            pick  <= scan_j;
            found <= 1'b1;
          end
          if ((step == sfp_pkg::SLOT_W'(1)) || (match && scan_j != top)) begin
            state <= ST_EMIT;
          end else begin
            step <= step - 1'b1;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            result_valid    <= 1'b1;
            fundamental_bin <= sfp_pkg::FUND_W'(pick);
            harmonic_found  <= found;
            for (int s = 0; s < sfp_pkg::NUM_PEAKS; s++) begin
              peak_power[s] <= '0;
              peak_index[s] <= '0;
            end
            state <= ST_UPDATE;
          end
        end
        default: state <= ST_UPDATE;
      endcase
    end
  end

endmodule

@@ hdl/spectral_fundamental_picker_unit.sv @@
// top level of the spectral fundamental picker
//
// bins enter on the bin channel (bin_valid / bin_stall), one per transfer, with
// their index counted from the start of the spectrum; last_bin closes a spectrum
// the result leaves on the result channel (result_valid / result_stall) as one
// transfer per spectrum: fundamental_bin and harmonic_found
// margin_frac (index 0) and first_bin (index 1) are written on the cfg port,
// which is always ready; writes to other indexes are dropped
// throughput: one bin per cycle while bin_stall is low; the front pipeline and
// the 8-entry queue feed the peak table, which updates once per cycle between
// spectrum ends; after its transfer the last bin passes 3 front stages, the
// queue and the table update, then follow 5 sort passes, the quotient step,
// 1 to 4 scan steps (one peak per step) and the result load
// the back end pops no bins during its end-of-spectrum work; bins keep flowing
// in meanwhile and bin_stall rises once queue and front stages hold 8 bins
// when the receiver stalls, the result holds in its register; the back end
// waits for it to drain before loading the next one, and the queue fills behind
// reset: synchronous, clears the table, bin counter, queue and result valid,
// and restores margin_frac = 1966 and first_bin = 10
module spectral_fundamental_picker_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               bin_valid,
  output logic                               bin_stall,
  input  logic signed [sfp_pkg::DATA_W-1:0]  bin_real,
  input  logic signed [sfp_pkg::DATA_W-1:0]  bin_imag,
  input  logic                               last_bin,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic [sfp_pkg::FUND_W-1:0]         fundamental_bin,
  output logic                               harmonic_found,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sfp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sfp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // configuration registers
  logic [sfp_pkg::MARGIN_W-1:0] margin_frac;
  logic [sfp_pkg::FIRST_W-1:0]  first_bin;

  // front to queue, queue to back
  logic                         push_valid;
  sfp_pkg::sfp_entry_t          push_data;
  sfp_pkg::sfp_entry_t          head;
  sfp_pkg::sfp_qstat_t          qstat;
  logic                         pop;

  // config writes always land, so the port never pushes back
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      margin_frac <= sfp_pkg::MARGIN_RESET;
      first_bin   <= sfp_pkg::FIRST_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sfp_pkg::REG_MARGIN: margin_frac <= cfg_data[sfp_pkg::MARGIN_W-1:0];
        sfp_pkg::REG_FIRST:  first_bin   <= cfg_data[sfp_pkg::FIRST_W-1:0];
        default: ;
      endcase
    end
  end

  // bin indexing, squares and spacing slack
  sfp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .bin_valid   (bin_valid),
    .bin_stall   (bin_stall),
    .bin_real    (bin_real),
    .bin_imag    (bin_imag),
    .last_bin    (last_bin),
    .margin_frac (margin_frac),
    .first_bin   (first_bin),
    .qstat       (qstat),
    .push_valid  (push_valid),
    .push_data   (push_data)
  );

  // decouples the streaming front from the end-of-spectrum work
  sfp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  // peak table, sort, harmonic scan and result register
  sfp_back u_back (
    .clk             (clk),
    .rst             (rst),
    .margin_frac     (margin_frac),
    .qstat           (qstat),
    .head            (head),
    .pop             (pop),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .fundamental_bin (fundamental_bin),
    .harmonic_found  (harmonic_found)
  );

endmodule

@@ hdl/sfp_checker.sv @@
// port-level checks of the spectral fundamental picker, bound to the top level
module sfp_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              result_valid,
  input logic                              result_stall,
  input logic [sfp_pkg::FUND_W-1:0]        fundamental_bin,
  input logic                              harmonic_found
);

  // stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(fundamental_bin) && $stable(harmonic_found))
    else $error("result changed while stalled");

  // result valid drops only after a transfer
  a_result_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(result_valid) |-> $past(!result_stall))
    else $error("result dropped without transfer");

  // no result can come out of the pipeline right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result_valid ##1 !result_valid ##1 !result_valid ##1 !result_valid)
    else $error("result too soon after reset");

  // a harmonic match needs a nonzero peak index
  a_match_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid && harmonic_found |-> fundamental_bin != '0)
    else $error("harmonic match on bin zero");

endmodule

bind spectral_fundamental_picker_unit sfp_checker u_chk (.*);
